@@ hdl/mst2_pkg.sv @@
// Shared types, codes and constants of the Track 2 magnetic-stripe decoder.
package mst2_pkg;

    localparam int CHAR_BITS    = 5;
    localparam int STORE_DEPTH  = 8;
    localparam int MAX_DIGITS   = 8;
    localparam int BYTE_BITS    = 8;
    localparam int ID_BITS      = STORE_DEPTH * BYTE_BITS;
    localparam int COUNT_BITS   = 4;
    localparam int INDEX_BITS   = 3;
    localparam int LEN_BITS     = 4;
    localparam int OP_BITS      = 2;
    localparam int CFG_ADDR_BITS = 1;

    localparam logic [COUNT_BITS-1:0] MAX_DIGITS_C = COUNT_BITS'(MAX_DIGITS);
    localparam logic [LEN_BITS-1:0]   ID_LEN_C     = LEN_BITS'(STORE_DEPTH);
    localparam logic [INDEX_BITS-1:0] LAST_BIT_C   = INDEX_BITS'(CHAR_BITS - 1);
    localparam logic [BYTE_BITS-1:0]  ASCII_ZERO   = 8'h30;

    // Operation codes carried in s_tuser
    localparam logic [OP_BITS-1:0] OP_CLOCK  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_ENABLE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_READ   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] REG_START_CODE = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_STOP_CODE  = 1'd1;

    localparam logic [CHAR_BITS-1:0] START_CODE_RST = 5'd11;
    localparam logic [CHAR_BITS-1:0] STOP_CODE_RST  = 5'd13;

    typedef struct packed {
        logic [ID_BITS-1:0]  card_id;
        logic [LEN_BITS-1:0] id_length;
        logic                read_valid;
        logic                id_ready;
    } result_t;

endpackage

@@ hdl/mst2_core.sv @@
// Decoder state and its next-state update for one registered input item.
module mst2_core #(
    parameter int MAX_DIGITS = mst2_pkg::MAX_DIGITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             item_valid,
    input  logic [mst2_pkg::OP_BITS-1:0]     item_op,
    input  logic                             item_level,
    input  logic [mst2_pkg::CHAR_BITS-1:0]   start_code,
    input  logic [mst2_pkg::CHAR_BITS-1:0]   stop_code,
    output mst2_pkg::result_t                result
);
    import mst2_pkg::*;

    localparam logic [COUNT_BITS-1:0] DIGIT_LIMIT = COUNT_BITS'(MAX_DIGITS);

    logic [CHAR_BITS-1:0]  window_reg,  window_next;
    logic [INDEX_BITS-1:0] bit_idx_reg, bit_idx_next;
    logic [COUNT_BITS-1:0] count_reg,   count_next;
    logic                  collect_reg, collect_next;
    logic                  ready_reg,   ready_next;
    logic [BYTE_BITS-1:0]  store_reg [STORE_DEPTH];

    logic                  bit_val;
    logic [CHAR_BITS-1:0]  shifted;
    logic [CHAR_BITS-1:0]  assembled;
    logic                  store_wr;
    logic [BYTE_BITS-1:0]  store_byte;
    logic [ID_BITS-1:0]    store_flat;

    assign bit_val    = ~item_level;
    assign shifted    = {bit_val, window_reg[CHAR_BITS-1:1]};
    assign assembled  = window_reg | (CHAR_BITS'(bit_val) << bit_idx_reg);
    assign store_byte = ASCII_ZERO + {4'd0, assembled[3:0]};

    always_comb begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            store_flat[i*BYTE_BITS +: BYTE_BITS] = store_reg[i];
        end
    end

    always_comb begin
        window_next  = window_reg;
        bit_idx_next = bit_idx_reg;
        count_next   = count_reg;
        collect_next = collect_reg;
        ready_next   = ready_reg;
        store_wr     = 1'b0;
        result       = '0;
        if (item_valid) begin
            case (item_op)
                OP_CLOCK: begin
                    if (!collect_reg) begin
                        // hunt for the start sentinel
                        if (shifted == start_code) begin
                            collect_next = 1'b1;
                            bit_idx_next = '0;
                            window_next  = '0;
                        end else begin
                            window_next = shifted;
                        end
                    end else if (bit_idx_reg == LAST_BIT_C) begin
                        bit_idx_next = '0;
                        window_next  = '0;
                        if (assembled == stop_code) begin
                            ready_next   = 1'b1;
                            collect_next = 1'b0;
                        end else if (count_reg < DIGIT_LIMIT) begin
                            store_wr   = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end else begin
                        window_next  = assembled;
                        bit_idx_next = bit_idx_reg + 1'b1;
                    end
                end
                OP_ENABLE: begin
                    window_next  = '0;
                    bit_idx_next = '0;
                    count_next   = '0;
                    collect_next = 1'b0;
                    ready_next   = 1'b0;
                end
                OP_READ: begin
                    if (ready_reg) begin
                        result.read_valid = 1'b1;
                        result.id_length  = ID_LEN_C;
                        result.card_id    = store_flat;
                        window_next  = '0;
                        bit_idx_next = '0;
                        count_next   = '0;
                        collect_next = 1'b0;
                        ready_next   = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
        result.id_ready = ready_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= '0;
            bit_idx_reg <= '0;
            count_reg   <= '0;
            collect_reg <= 1'b0;
            ready_reg   <= 1'b0;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                store_reg[i] <= '0;
            end
        end else begin
            window_reg  <= window_next;
            bit_idx_reg <= bit_idx_next;
            count_reg   <= count_next;
            collect_reg <= collect_next;
            ready_reg   <= ready_next;
            if (store_wr) begin
                store_reg[count_reg[INDEX_BITS-1:0]] <= store_byte;
            end
        end
    end

endmodule

@@ hdl/mst2_skid.sv @@
// Two-entry result buffer: output register plus skid register.
module mst2_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mst2_pkg::result_t push_data,
    output logic              can_push,
    output logic              out_valid,
    output mst2_pkg::result_t out_data,
    input  logic              out_ready
);
    import mst2_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    pop;

    assign pop       = main_valid_reg & out_ready;
    assign can_push  = ~skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (pop && skid_valid_reg) begin
            // drain the skid entry; no push is taken in this cycle
            main_next       = skid_reg;
            skid_valid_next = 1'b0;
        end else if (pop || !main_valid_reg) begin
            main_valid_next = push;
            main_next       = push_data;
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

@@ hdl/magstripe_track2_decoder.sv @@
// Top level of the Track 2 magnetic-stripe decoder with stream ports.
//
// The block decodes a Track 2 bit stream delivered one event per transaction:
// a reader clock edge with the raw (active-low) data level, an enable edge
// that restarts the card, or a read request. Characters are 5 bits, LSB
// first; the block hunts for start_code, then stores each character other
// than stop_code as ASCII '0' plus its low nibble, up to MAX_DIGITS. stop_code
// raises the ready flag (id_ready); a read while ready returns all eight
// stored bytes and clears the control state, while the stored bytes persist
// across cards. Every input transaction yields exactly one result
// transaction. Throughput is one transaction per clock while the result
// buffer has room: the state update lies between the input register and
// the result buffer. A result passes through the input register and the
// result buffer's output register before it appears on m_tvalid.
// A two-entry result buffer lets the input side keep accepting while a
// result waits; with m_tready held low, three transactions are held before
// s_tready drops. Write start_code and stop_code only while no transaction
// is in flight.
module magstripe_track2_decoder #(
    parameter int MAX_DIGITS = mst2_pkg::MAX_DIGITS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input channel
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,  // [0] data_level, [7:1] zero
    input  logic [mst2_pkg::OP_BITS-1:0]         s_tuser,  // [1:0] operation
    // result channel
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [71:0]                          m_tdata,  // [0] id_ready,
                                                           // [4:1] id_length,
                                                           // [68:5] card_id,
                                                           // [71:69] zero
    output logic                                 m_tuser,  // [0] read_valid
    // configuration
    input  logic                                 cfg_wr_en,
    input  logic [mst2_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  logic [mst2_pkg::CHAR_BITS-1:0]       cfg_wdata
);
    import mst2_pkg::*;

    logic                 in_valid_reg, in_valid_next;
    logic [OP_BITS-1:0]   in_op_reg;
    logic                 in_level_reg;
    logic [CHAR_BITS-1:0] start_code_reg;
    logic [CHAR_BITS-1:0] stop_code_reg;
    logic                 can_push;
    logic                 advance;
    logic                 in_accept;
    result_t              core_result;
    result_t              out_result;

    // The registered item moves on when the result buffer has room
    assign advance   = in_valid_reg & can_push;
    assign s_tready  = ~in_valid_reg | can_push;
    assign in_accept = s_tvalid & s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    // Input register: hold the transaction until the core consumes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (in_accept) begin
            in_op_reg    <= s_tuser;
            in_level_reg <= s_tdata[0];
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_code_reg <= START_CODE_RST;
            stop_code_reg  <= STOP_CODE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_START_CODE: start_code_reg <= cfg_wdata;
                REG_STOP_CODE:  stop_code_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    mst2_core #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (advance),
        .item_op    (in_op_reg),
        .item_level (in_level_reg),
        .start_code (start_code_reg),
        .stop_code  (stop_code_reg),
        .result     (core_result)
    );

    mst2_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (advance),
        .push_data (core_result),
        .can_push  (can_push),
        .out_valid (m_tvalid),
        .out_data  (out_result),
        .out_ready (m_tready)
    );

    assign m_tdata = {3'b000, out_result.card_id, out_result.id_length,
                      out_result.id_ready};
    assign m_tuser = out_result.read_valid;

    // A returned id always carries eight bytes, and the read clears ready
    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[4:1] == ID_LEN_C && !m_tdata[0]))
        else $error("read result with bad length or ready still set");

    // Back-pressure on the input only while an item is held
    a_stall_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg)
        else $error("input stalled with empty input register");

    // An accepted transaction occupies the input register next cycle
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> in_valid_reg)
        else $error("accepted transaction lost");

endmodule
